// ----- sv/ers_pkg.sv -----
package ers_pkg;

	localparam int DEF_IN_SIZE          = 8;
	localparam int DEF_UNITS            = 8;
	localparam int DEF_TANH_TABLE_DEPTH = 256;

	// Fixed widths of command fields; user keeps UNITS <= 8, IN_SIZE < 64, unchecked
	localparam int ADDR_W = 6;
	localparam int UNIT_W = 3;

	localparam logic [2:0] KIND_IN_WEIGHT  = 3'd0;
	localparam logic [2:0] KIND_REC_WEIGHT = 3'd1;
	localparam logic [2:0] KIND_BIAS       = 3'd2;
	localparam logic [2:0] KIND_START      = 3'd3;
	localparam logic [2:0] KIND_INIT_HID   = 3'd4;
	localparam logic [2:0] KIND_ELEMENT    = 3'd5;

	localparam logic [63:0] Q30_ONE       = 64'd1073741824;
	localparam logic [63:0] EXP_M1_Q30    = 64'd395007542;

	typedef struct packed {
		logic              in_rdy;
		logic              rd_en;
		logic              rd_rec;
		logic [ADDR_W-1:0] rd_addr;
		logic              fin;
		logic [UNIT_W-1:0] unit;
	} ers_cmd_t;

	typedef struct packed {
		logic step_go;
		logic busy;
		logic out_taken;
	} ers_stat_t;

	// Restoring division, used only while building the tanh table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^(-y) in Q30 for y in Q12
	function automatic logic [63:0] exp_neg_q30(input logic [31:0] y);
		logic [31:0]        k;
		logic [63:0]        f;
		logic [63:0]        e;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		k   = y >> 12;
		f   = 64'(y & 32'd4095);
		e   = Q30_ONE;
		mag = Q30_ONE;
		sum = $signed(Q30_ONE);
		for (int i = 0; i < 32'(k); i++) begin
			e = (e * EXP_M1_Q30 + (Q30_ONE >> 1)) >> 30;
		end
		for (int i = 1; i <= 12; i++) begin
			mag = udiv64(mag * f, 64'd4096 * 64'(i));
			if ((i % 2) == 1) begin
				sum = sum - $signed(mag);
			end else begin
				sum = sum + $signed(mag);
			end
		end
		return (e * 64'(sum) + (Q30_ONE >> 1)) >> 30;
	endfunction

	// tanh of a nonnegative Q3.12 magnitude, Q3.12 result
	function automatic logic [15:0] tanh_point(input logic [31:0] xm);
		logic [63:0] t;
		logic [63:0] num;
		logic [63:0] den;
		t   = exp_neg_q30(2 * xm);
		num = (Q30_ONE - t) * 64'd8192 + (Q30_ONE + t);
		den = 64'd2 * (Q30_ONE + t);
		return 16'(udiv64(num, den));
	endfunction

endpackage

// ----- sv/ers_in_if.sv -----
interface ers_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [2:0]         row;
	logic [2:0]         col;
	logic signed [15:0] value;
	logic [15:0]        step_limit;
	logic               last_element;

	modport source (output valid, kind, row, col, value, step_limit, last_element,
		input ready);
	modport sink (input valid, kind, row, col, value, step_limit, last_element,
		output ready);
endinterface

// ----- sv/ers_out_if.sv -----
interface ers_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         unit;
	logic signed [15:0] hidden_value;
	logic               last;

	modport source (output valid, unit, hidden_value, last, input ready);
	modport sink (input valid, unit, hidden_value, last, output ready);
endinterface

// ----- sv/ers_ctrl.sv -----
module ers_ctrl
	import ers_pkg::*;
#(
	parameter int IN_SIZE = DEF_IN_SIZE,
	parameter int UNITS   = DEF_UNITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ers_stat_t stat,
	output ers_cmd_t  cmd
);

	localparam int N  = IN_SIZE + UNITS;
	localparam int CW = $clog2(N);

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_FIN, S_WAIT} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [UNIT_W-1:0]   unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			unit_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (stat.step_go) begin
						state_q <= S_MAC;
						cnt_q   <= '0;
					end
				end
				S_MAC: begin
					if (cnt_q == CW'(N - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!stat.busy) begin
						state_q <= S_FIN;
						unit_q  <= '0;
					end
				end
				S_FIN: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.out_taken) begin
						if (unit_q == UNIT_W'(UNITS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							unit_q  <= unit_q + 1'b1;
							state_q <= S_FIN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.in_rdy  = (state_q == S_IDLE);
		cmd.rd_en   = (state_q == S_MAC);
		cmd.rd_rec  = (32'(cnt_q) >= IN_SIZE);
		cmd.rd_addr = cmd.rd_rec ? ADDR_W'(32'(cnt_q) - IN_SIZE) : ADDR_W'(cnt_q);
		cmd.fin     = (state_q == S_FIN);
		cmd.unit    = unit_q;
	end

endmodule

// ----- sv/ers_dp.sv -----
module ers_dp
	import ers_pkg::*;
#(
	parameter int IN_SIZE          = DEF_IN_SIZE,
	parameter int UNITS            = DEF_UNITS,
	parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ers_in_if.sink    sample,
	ers_out_if.source result,
	input  ers_cmd_t  cmd,
	output ers_stat_t stat
);

	localparam int XW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
	localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int AW = 33 + $clog2(IN_SIZE + UNITS + 2);
	localparam int D  = TANH_TABLE_DEPTH;
	localparam int LW = $clog2(D + 1);
	localparam int PW = 17 + $clog2(D + 1);

	typedef logic signed [15:0] q_t;

	// Tanh table, built at elaboration
	logic [15:0] lut [D+1];
	for (genvar gi = 0; gi <= D; gi++) begin : g_lut
		localparam logic [15:0] PT = tanh_point(32'(gi * 32768 / D));
		assign lut[gi] = PT;
	end

	// Stores
	logic [UNITS-1:0][15:0] wx_mem [IN_SIZE];
	logic [UNITS-1:0][15:0] wh_mem [UNITS];
	q_t                     xbuf_mem [IN_SIZE];
	q_t                     bias_q [2][UNITS];
	q_t                     hid_q [UNITS];
	logic [15:0]            step_cnt_q;
	logic [15:0]            limit_q;
	logic                   active_q;

	logic          accept;
	logic [XW-1:0] row_x;
	logic [UW-1:0] row_u;
	logic [UW-1:0] col_u;
	logic          row_x_ok;
	logic          row_u_ok;
	logic          col_ok;
	logic          step_go;

	assign sample.ready = cmd.in_rdy;
	assign accept   = sample.valid & sample.ready;
	assign row_x    = XW'(sample.row);
	assign row_u    = UW'(sample.row);
	assign col_u    = UW'(sample.col);
	assign row_x_ok = (32'(sample.row) < IN_SIZE);
	assign row_u_ok = (32'(sample.row) < UNITS);
	assign col_ok   = (32'(sample.col) < UNITS);
	assign step_go  = accept && (sample.kind == KIND_ELEMENT) && sample.last_element;

	// Weight and input memories: one write port, one registered read; bias writes too
	always_ff @(posedge clk) begin
		if (accept && sample.kind == KIND_IN_WEIGHT && row_x_ok && col_ok) begin
			wx_mem[row_x][col_u] <= sample.value;
		end
		if (accept && sample.kind == KIND_REC_WEIGHT && row_u_ok && col_ok) begin
			wh_mem[row_u][col_u] <= sample.value;
		end
		if (accept && sample.kind == KIND_ELEMENT && row_x_ok) begin
			xbuf_mem[row_x] <= sample.value;
		end
		if (accept && sample.kind == KIND_BIAS && sample.row < 3'd2 && col_ok) begin
			bias_q[sample.row[0]][col_u] <= sample.value;
		end
	end

	// MAC read stage
	logic                   v_s1;
	logic                   v_s2;
	q_t                     x_s1;
	logic [UNITS-1:0][15:0] w_s1;
	logic signed [31:0]     prod_s2 [UNITS];
	logic signed [AW-1:0]   acc_q [UNITS];

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			if (cmd.rd_rec) begin
				x_s1 <= hid_q[cmd.rd_addr[UW-1:0]];
				w_s1 <= wh_mem[cmd.rd_addr[UW-1:0]];
			end else begin
				x_s1 <= xbuf_mem[cmd.rd_addr[XW-1:0]];
				w_s1 <= wx_mem[cmd.rd_addr[XW-1:0]];
			end
		end
	end

	// One multiplier per unit lane
	for (genvar gj = 0; gj < UNITS; gj++) begin : g_lane
		always_ff @(posedge clk) begin
			prod_s2[gj] <= x_s1 * $signed(w_s1[gj]);
			if (step_go) begin
				acc_q[gj] <= (AW'(bias_q[0][gj]) + AW'(bias_q[1][gj])) <<< 12;
			end else if (v_s2) begin
				acc_q[gj] <= acc_q[gj] + AW'(prod_s2[gj]);
			end
		end
	end

	// Finish pipeline: round and saturate, index, table read, interpolate, output
	logic                 fv_s1, fv_s2, fv_s3, fv_s4;
	logic signed [AW-1:0] r_sum;
	logic signed [AW-1:0] r_q;
	q_t                   s_s1;
	logic signed [16:0]   s_ext;
	logic [16:0]          m_mag;
	logic [PW-1:0]        pos;
	logic [PW-16:0]       pos_idx;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [LW-1:0]        idx_s2;
	logic [LW-1:0]        idx_b;
	logic [14:0]          frac_s2, frac_s3;
	logic [15:0]          a_s3, b_s3, a_s4;
	logic [15:0]          d_s3;
	logic [30:0]          dp_s4;
	logic [31:0]          rnd;
	logic [15:0]          v_mag;
	q_t                   v_out;
	logic                 out_valid_q;
	logic [UW-1:0]        out_unit_q;
	q_t                   out_val_q;

	assign r_sum   = acc_q[cmd.unit[UW-1:0]] + AW'(2048);
	assign r_q     = r_sum >>> 12;
	assign s_ext   = 17'(s_s1);
	assign m_mag   = s_s1[15] ? 17'(-s_ext) : 17'(s_ext);
	assign pos     = PW'(m_mag) * PW'(D);
	assign pos_idx = pos[PW-1:15];
	assign idx_b   = (idx_s2 == LW'(D)) ? idx_s2 : idx_s2 + 1'b1;
	assign d_s3    = (b_s3 >= a_s3) ? b_s3 - a_s3 : 16'd0;
	assign rnd     = 32'(dp_s4) + 32'd16384;
	assign v_mag   = a_s4 + 16'(rnd >> 15);
	assign v_out   = neg_s4 ? -$signed(v_mag) : $signed(v_mag);

	always_ff @(posedge clk) begin
		if (r_q > AW'(32767)) begin
			s_s1 <= 16'sd32767;
		end else if (r_q < -AW'(32768)) begin
			s_s1 <= -16'sd32768;
		end else begin
			s_s1 <= 16'(r_q);
		end
		neg_s2 <= s_s1[15];
		if (32'(pos_idx) >= D) begin
			idx_s2  <= LW'(D);
			frac_s2 <= '0;
		end else begin
			idx_s2  <= LW'(pos_idx);
			frac_s2 <= pos[14:0];
		end
		a_s3    <= lut[idx_s2];
		b_s3    <= lut[idx_b];
		frac_s3 <= frac_s2;
		neg_s3  <= neg_s2;
		dp_s4   <= d_s3 * frac_s3;
		a_s4    <= a_s3;
		neg_s4  <= neg_s3;
		if (fv_s4) begin
			out_val_q  <= active_q ? v_out : '0;
			out_unit_q <= cmd.unit[UW-1:0];
		end
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fv_s1       <= 1'b0;
			fv_s2       <= 1'b0;
			fv_s3       <= 1'b0;
			fv_s4       <= 1'b0;
			out_valid_q <= 1'b0;
			step_cnt_q  <= '0;
			limit_q     <= '0;
			active_q    <= 1'b0;
			for (int j = 0; j < UNITS; j++) begin
				hid_q[j] <= '0;
			end
		end else begin
			v_s1  <= cmd.rd_en;
			v_s2  <= v_s1;
			fv_s1 <= cmd.fin;
			fv_s2 <= fv_s1;
			fv_s3 <= fv_s2;
			fv_s4 <= fv_s3;
			if (fv_s4) begin
				out_valid_q <= 1'b1;
				if (active_q) begin
					hid_q[cmd.unit[UW-1:0]] <= v_out;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && sample.kind == KIND_START) begin
				limit_q    <= sample.step_limit;
				step_cnt_q <= '0;
				for (int j = 0; j < UNITS; j++) begin
					hid_q[j] <= '0;
				end
			end
			if (accept && sample.kind == KIND_INIT_HID && col_ok) begin
				hid_q[col_u] <= sample.value;
			end
			if (step_go) begin
				active_q <= (step_cnt_q < limit_q);
				if (step_cnt_q != 16'hFFFF) begin
					step_cnt_q <= step_cnt_q + 1'b1;
				end
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.unit         = 3'(out_unit_q);
	assign result.hidden_value = out_val_q;
	assign result.last         = (out_unit_q == UW'(UNITS - 1));

	assign stat.step_go   = step_go;
	assign stat.busy      = v_s1 | v_s2;
	assign stat.out_taken = out_valid_q & result.ready;

endmodule

// ----- sv/elman_rnn_sequence_step.sv -----
// Elman recurrent cell, h = tanh(Wx*x + bx + Wh*h + bh), Q3.12 data, one
// sequence at a time. Load weights, biases and initial hidden values with
// single items. Start a sequence to clear h, set the step limit and zero
// the step count. Send the input vector element by element; the element
// marked last runs a step and the block returns UNITS results, unit 0
// first, last set on unit UNITS-1. Steps at or past the limit return zeros
// and keep h. The sum is kept exactly in a wide accumulator, rounded half
// up and saturated to Q3.12, then passed through an interpolated tanh
// table of TANH_TABLE_DEPTH+1 points. A step first multiplies and
// accumulates one input or hidden element a cycle (one multiplier per
// hidden unit, weights from the weight memories), then passes each unit in
// turn through the shared round, tanh and interpolation pipeline, waiting
// out any stall on the result side. No item is taken until the last
// result of a step has been accepted. Weight, bias and input stores hold
// junk until written.
module elman_rnn_sequence_step
	import ers_pkg::*;
#(
	parameter int IN_SIZE          = DEF_IN_SIZE,
	parameter int UNITS            = DEF_UNITS,
	parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	ers_in_if.sink    sample,
	ers_out_if.source result
);

	// Command and status between sequencer and datapath
	ers_cmd_t  cmd;
	ers_stat_t stat;

	// Sequencer: idle, run the MAC sweep, drain, then finish one unit at a time
	ers_ctrl #(
		.IN_SIZE (IN_SIZE),
		.UNITS   (UNITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Stores, unit lanes, tanh pipeline and result register
	ers_dp #(
		.IN_SIZE          (IN_SIZE),
		.UNITS            (UNITS),
		.TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
